### rtl/mbps_pkg.sv
// Shared constants, codes and transfer types of the masked byte pattern scanner.
package mbps_pkg;

    localparam int MBPS_MAX_PATTERN = 256;
    localparam int BYTE_W           = 8;
    localparam int IDX_W            = 8;
    localparam int CFG_LEN_W        = 9;
    localparam int OFS_W            = 32;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    localparam logic [OFS_W-1:0] OFS_MAX = '1;

    // Register index, taken from the word address bit of paddr
    localparam logic REG_PATTERN_LENGTH = 1'b0;

    // Input item kinds
    localparam logic ACT_PATTERN = 1'b0;
    localparam logic ACT_DATA    = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_REPLAY
    } t_state;

    // Pattern entry write, broadcast to every cell
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
        logic              wild;
    } t_pat_wr;

    // Window step, broadcast to every cell
    typedef struct packed {
        logic              en;
        logic              clr;
        logic [BYTE_W-1:0] data;
    } t_step;

endpackage

### rtl/mbps_if.sv
// Valid/ready channel interfaces for scan items and scan results.
interface mbps_in_if;
    import mbps_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [IDX_W-1:0]  pattern_index;
    logic [BYTE_W-1:0] value;
    logic              wildcard_req;
    logic              last;

    modport source (
        output valid, action, pattern_index, value, wildcard_req, last,
        input  ready
    );
    modport sink (
        input  valid, action, pattern_index, value, wildcard_req, last,
        output ready
    );
endinterface

interface mbps_out_if;
    import mbps_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [OFS_W-1:0] match_offset;

    modport source (
        output valid, found, match_offset,
        input  ready
    );
    modport sink (
        input  valid, found, match_offset,
        output ready
    );
endinterface

### rtl/mbps_cell.sv
// One chain cell: a pattern entry, one window byte and one partial-match bit.
module mbps_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mbps_pkg::t_pat_wr           i_pat,
    input  mbps_pkg::t_step             i_step,
    input  logic                        i_prev_hit,
    input  logic [mbps_pkg::BYTE_W-1:0] i_win_next,
    output logic                        o_hit,
    output logic                        o_hit_next,
    output logic [mbps_pkg::BYTE_W-1:0] o_win
);
    import mbps_pkg::*;

    logic [BYTE_W-1:0] r_pat_byte;
    logic              r_pat_wild;
    logic              r_hit;
    logic [BYTE_W-1:0] r_win;
    logic              w_sel;
    logic              n_hit;

    assign w_sel = i_pat.en && (int'(i_pat.idx) == IDX);

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_pat_byte <= i_pat.data;
            r_pat_wild <= i_pat.wild;
        end
    end

    // Entries 0..IDX match the newest IDX+1 bytes when the neighbor did one byte ago
    assign n_hit = i_prev_hit && (r_pat_wild || (r_pat_byte == i_step.data));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_win <= '0;
        end else if (i_step.clr) begin
            r_hit <= 1'b0;
        end else if (i_step.en) begin
            r_hit <= n_hit;
            r_win <= i_win_next;
        end
    end

    assign o_hit      = r_hit;
    assign o_hit_next = n_hit;
    assign o_win      = r_win;

endmodule

### rtl/mbps_apb.sv
// Configuration register file: pattern length with clamping to the chain size.
module mbps_apb #(
    parameter int MAX_PATTERN = mbps_pkg::MBPS_MAX_PATTERN,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1),
    parameter int LIDX_W      = $clog2(MAX_PATTERN)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mbps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mbps_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [LEN_W-1:0]                o_len,
    output logic [LIDX_W-1:0]               o_len_m1
);
    import mbps_pkg::*;

    localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;

    logic [CFG_LEN_W-1:0] r_len;
    logic [CMP_W-1:0]     w_len_raw;
    logic [CMP_W-1:0]     w_len_c;
    logic                 w_reg_sel;

    assign w_reg_sel = (paddr[2] == REG_PATTERN_LENGTH);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= CFG_LEN_W'(1);
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_len <= pwdata[CFG_LEN_W-1:0];
        end
    end

    assign prdata = w_reg_sel ? APB_DATA_W'(r_len) : '0;

    // Zero acts as one, anything above the chain size as the chain size
    always_comb begin
        w_len_raw = CMP_W'(r_len);
        if (w_len_raw == '0) begin
            w_len_c = CMP_W'(1);
        end else if (w_len_raw > CMP_W'(MAX_PATTERN)) begin
            w_len_c = CMP_W'(MAX_PATTERN);
        end else begin
            w_len_c = w_len_raw;
        end
    end

    assign o_len    = LEN_W'(w_len_c);
    assign o_len_m1 = LIDX_W'(w_len_c - CMP_W'(1));

endmodule

### rtl/masked_byte_pattern_scan.sv
// Masked byte pattern scanner: top level with cell chain, control and result register.
// Pattern entries (byte plus wildcard mark) and region bytes arrive on one valid/ready
// channel; the first window whose non-wildcard entries all equal their bytes is reported
// with its start offset, and a region that ends without a match reports not found.
// A chain of MAX_PATTERN cells holds the pattern, the newest MAX_PATTERN bytes and one
// partial-match bit per entry, so a region byte is taken every cycle unless a rebuild
// is due, and its result is in the output register right after the edge that accepts
// the byte; a result that waits for o_res.ready holds off the next input transaction
// until the edge at which it leaves. After one or more pattern writes the first region
// byte waits while the partial-match bits are cleared and a replay then rotates the
// window once through the chain to rebuild them; further pattern writes alone add no
// replay. pattern_length is set through the APB port at byte address 0.
module masked_byte_pattern_scan #(
    parameter int MAX_PATTERN = mbps_pkg::MBPS_MAX_PATTERN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mbps_in_if.sink                         i_scan,
    mbps_out_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mbps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mbps_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import mbps_pkg::*;

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int LIDX_W = $clog2(MAX_PATTERN);

    logic [LEN_W-1:0]       w_len;
    logic [LIDX_W-1:0]      w_len_m1;
    logic [MAX_PATTERN-1:0] w_hit;
    logic [MAX_PATTERN-1:0] w_hit_next;
    logic [BYTE_W-1:0]      w_win [MAX_PATTERN];
    logic [BYTE_W-1:0]      w_head;
    t_pat_wr                w_pat;
    t_step                  w_step;
    logic                   w_ready;
    logic [OFS_W-1:0]       w_seen_inc;
    logic                   w_hit_now;

    t_state             r_state, n_state;
    logic               r_dirty, n_dirty;
    logic [LIDX_W-1:0]  r_cnt, n_cnt;
    logic [OFS_W-1:0]   r_seen, n_seen;
    logic               r_matched, n_matched;
    logic               r_res_valid, n_res_valid;
    logic               r_found, n_found;
    logic [OFS_W-1:0]   r_ofs, n_ofs;

    mbps_apb #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W),
        .LIDX_W      (LIDX_W)
    ) u_apb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_len    (w_len),
        .o_len_m1 (w_len_m1)
    );

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        logic              w_prev;
        logic [BYTE_W-1:0] w_nb;

        if (g == 0) begin : g_first
            assign w_prev = 1'b1;
        end else begin : g_mid
            assign w_prev = w_hit[g-1];
        end

        if (g == MAX_PATTERN - 1) begin : g_newest
            assign w_nb = w_head;
        end else begin : g_older
            assign w_nb = w_win[g+1];
        end

        mbps_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_pat      (w_pat),
            .i_step     (w_step),
            .i_prev_hit (w_prev),
            .i_win_next (w_nb),
            .o_hit      (w_hit[g]),
            .o_hit_next (w_hit_next[g]),
            .o_win      (w_win[g])
        );
    end

    assign w_seen_inc = (r_seen == OFS_MAX) ? r_seen : r_seen + OFS_W'(1);
    assign w_hit_now  = !r_matched && (w_seen_inc >= OFS_W'(w_len)) && w_hit_next[w_len_m1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dirty     <= 1'b0;
            r_cnt       <= '0;
            r_seen      <= '0;
            r_matched   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dirty     <= n_dirty;
            r_cnt       <= n_cnt;
            r_seen      <= n_seen;
            r_matched   <= n_matched;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_ofs   <= n_ofs;
    end

    always_comb begin
        n_state     = r_state;
        n_dirty     = r_dirty;
        n_cnt       = r_cnt;
        n_seen      = r_seen;
        n_matched   = r_matched;
        n_res_valid = r_res_valid && !o_res.ready;
        n_found     = r_found;
        n_ofs       = r_ofs;
        w_ready     = 1'b0;
        w_head      = i_scan.value;
        w_pat       = '{en: 1'b0, idx: i_scan.pattern_index, data: i_scan.value,
                        wild: i_scan.wildcard_req};
        w_step      = '{en: 1'b0, clr: 1'b0, data: i_scan.value};

        unique case (r_state)
            ST_IDLE: begin
                w_ready = !(r_dirty && (i_scan.action == ACT_DATA))
                          && (!r_res_valid || o_res.ready);
                if (i_scan.valid && r_dirty && (i_scan.action == ACT_DATA)) begin
                    // stale partial-match bits: clear and rebuild before taking the byte
                    w_step.clr = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_REPLAY;
                end else if (i_scan.valid && w_ready) begin
                    if (i_scan.action == ACT_PATTERN) begin
                        w_pat.en = 1'b1;
                        n_dirty  = 1'b1;
                    end else begin
                        w_step.en = 1'b1;
                        n_seen    = i_scan.last ? '0 : w_seen_inc;
                        n_matched = i_scan.last ? 1'b0 : (r_matched || w_hit_now);
                        if (w_hit_now) begin
                            n_res_valid = 1'b1;
                            n_found     = 1'b1;
                            n_ofs       = w_seen_inc - OFS_W'(w_len);
                        end else if (i_scan.last && !r_matched) begin
                            n_res_valid = 1'b1;
                            n_found     = 1'b0;
                            n_ofs       = '0;
                        end
                    end
                end
            end
            ST_REPLAY: begin
                // rotate the oldest byte back in as the newest
                w_step.en   = 1'b1;
                w_step.data = w_win[0];
                w_head      = w_win[0];
                n_cnt       = LIDX_W'(r_cnt + LIDX_W'(1));
                if (r_cnt == LIDX_W'(MAX_PATTERN - 1)) begin
                    n_state = ST_IDLE;
                    n_dirty = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_scan.ready       = w_ready;
    assign o_res.valid        = r_res_valid;
    assign o_res.found        = r_found;
    assign o_res.match_offset = r_ofs;

endmodule

### rtl/mbps_check.sv
// Port-level checker for the masked byte pattern scanner, bound to the top level.
module mbps_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_action,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_found,
    input logic [mbps_pkg::OFS_W-1:0]  i_out_offset
);
    import mbps_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_found) && $stable(i_out_offset))
        else $error("result changed while stalled");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_offset == '0)
        else $error("not-found result carries a nonzero offset");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && (i_in_action == ACT_DATA)))
        else $error("result without a preceding region byte transaction");

    a_pattern_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action == ACT_PATTERN)
            && (!i_out_valid || i_out_ready) |=> !i_out_valid)
        else $error("pattern write produced a result");

endmodule

bind masked_byte_pattern_scan mbps_check u_mbps_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_scan.valid),
    .i_in_ready   (i_scan.ready),
    .i_in_action  (i_scan.action),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_found  (o_res.found),
    .i_out_offset (o_res.match_offset)
);
